// ----- src/plm_pkg.sv -----
// shared types and constants of the peak level meter
package plm_pkg;

	localparam int Channels    = 8;
	localparam int ChWidth     = 3;
	localparam int SampleWidth = 24;
	localparam int LevelWidth  = 16;
	localparam int GainWidth   = 16;
	localparam int ShiftWidth  = 5;
	localparam int MantWidth   = 31;
	localparam int FracWidth   = 16;
	localparam int SqSteps     = 16;
	localparam int QueueDepth  = 4;
	localparam int PaddrWidth  = 3;

	localparam logic [GainWidth-1:0] GainReset   = 16'd3277;
	localparam logic [20:0]          LogScaleQ16 = 21'd1578264;
	localparam logic [7:0]           FloorLevel  = 8'd8;
	localparam logic [7:0]           TopLevel    = 8'd248;
	localparam logic [10:0]          FloorSteps  = 11'd240;

	typedef enum logic [0:0] {
		RegDecayGain = 1'b0
	} reg_index_t;

	typedef struct packed {
		logic [ChWidth-1:0]     ch;
		logic [SampleWidth-1:0] peak;
	} queue_item_t;

	typedef struct packed {
		logic        not_empty;
		logic        not_full;
		queue_item_t head;
	} queue_status_t;

endpackage

// ----- src/plm_if.sv -----
// stream channel interfaces for samples and meter results
interface plm_in_if;
	logic                                valid;
	logic                                ready;
	logic [plm_pkg::ChWidth-1:0]         channel;
	logic signed [plm_pkg::SampleWidth-1:0] sample_value;
	logic                                last_of_buffer;

	modport source (output valid, channel, sample_value, last_of_buffer, input ready);
	modport sink (input valid, channel, sample_value, last_of_buffer, output ready);
endinterface

interface plm_out_if;
	logic                             valid;
	logic                             ready;
	logic [plm_pkg::ChWidth-1:0]      meter_channel;
	logic [plm_pkg::LevelWidth-1:0]   meter_level;

	modport source (output valid, meter_channel, meter_level, input ready);
	modport sink (input valid, meter_channel, meter_level, output ready);
endinterface

// ----- src/peak_level_meter.sv -----
// top level of the per-channel peak level meter
//
// samples: stream of transactions (channel, sample_value, last_of_buffer).
//   a transaction is taken when valid and ready are high; while the queue
//   has room one per cycle is sustained; the channel peak updates at once.
// meter: one transaction per buffer end (meter_channel, meter_level),
//   meter_level in Q8.8 quarter-dB steps, integer part 8..248.
// path: the peak of a buffer end passes the queue, the normalize stage,
//   the 16-step log2 squaring pipeline, the scale and target stages and
//   the release logic into the output register.
// throughput: one sample and one result per cycle when meter.ready is high.
// a four-entry queue parts the sample side from the log pipeline; when
//   the meter receiver stalls the pipeline holds, the queue fills and
//   samples.ready falls only once it is full.
// apb: decay_gain where paddr[2] is low, Q0.16 release fraction per buffer.
// reset clears all peaks, meter values, the queue and the pipeline, and
//   loads decay_gain with its default.
module peak_level_meter (
	input  logic                              clk,
	input  logic                              arst_n,
	plm_in_if.sink                            samples,
	plm_out_if.source                         meter,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [plm_pkg::PaddrWidth-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [plm_pkg::GainWidth-1:0] decay_gain_q;
	plm_pkg::queue_status_t        q_status;
	plm_pkg::queue_item_t          push_item;
	logic                          push;
	logic                          pop;
	plm_pkg::reg_index_t           reg_idx;
	logic                          idx_ok;

	assign pready  = 1'b1;
	assign reg_idx = plm_pkg::reg_index_t'(paddr[2]);
	assign idx_ok  = reg_idx == plm_pkg::RegDecayGain;
	assign prdata  = idx_ok ? {16'b0, decay_gain_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_gain_q <= plm_pkg::GainReset;
		end else if (psel && penable && pwrite && pready && idx_ok) begin
			decay_gain_q <= pwdata[plm_pkg::GainWidth-1:0];
		end
	end

	plm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (samples.valid),
		.in_ready   (samples.ready),
		.in_channel (samples.channel),
		.in_sample  (samples.sample_value),
		.in_last    (samples.last_of_buffer),
		.q_status   (q_status),
		.push       (push),
		.push_item  (push_item)
	);

	plm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.status    (q_status)
	);

	plm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.pop         (pop),
		.decay_gain  (decay_gain_q),
		.out_valid   (meter.valid),
		.out_ready   (meter.ready),
		.out_channel (meter.meter_channel),
		.out_level   (meter.meter_level)
	);

endmodule

// ----- src/plm_front.sv -----
// front end: magnitude, per-channel peak tracking, buffer end detection
module plm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [plm_pkg::ChWidth-1:0]       in_channel,
	input  logic signed [plm_pkg::SampleWidth-1:0] in_sample,
	input  logic                              in_last,
	input  plm_pkg::queue_status_t            q_status,
	output logic                              push,
	output plm_pkg::queue_item_t              push_item
);

	logic [plm_pkg::SampleWidth-1:0] peak_q [plm_pkg::Channels];
	logic [plm_pkg::SampleWidth-1:0] mag;
	logic [plm_pkg::SampleWidth-1:0] cur_peak;
	logic [plm_pkg::SampleWidth-1:0] new_peak;
	logic                            ch_ok;
	logic                            accept;

	assign in_ready = q_status.not_full;
	assign accept   = in_valid && in_ready;
	assign ch_ok    = int'(in_channel) < plm_pkg::Channels;
	assign mag      = in_sample[plm_pkg::SampleWidth-1] ? (~in_sample + 1'b1) : in_sample;
	assign cur_peak = ch_ok ? peak_q[in_channel] : '0;
	assign new_peak = (mag > cur_peak) ? mag : cur_peak;

	assign push           = accept && ch_ok && in_last;
	assign push_item.ch   = in_channel;
	assign push_item.peak = new_peak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < plm_pkg::Channels; i++) begin
				peak_q[i] <= '0;
			end
		end else if (accept && ch_ok) begin
			peak_q[in_channel] <= in_last ? '0 : new_peak;
		end
	end

endmodule

// ----- src/plm_queue.sv -----
// short queue of finished buffers between front and back
module plm_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  plm_pkg::queue_item_t   push_item,
	input  logic                   pop,
	output plm_pkg::queue_status_t status
);

	localparam int IdxWidth = $clog2(plm_pkg::QueueDepth);
	localparam int CntWidth = $clog2(plm_pkg::QueueDepth + 1);

	plm_pkg::queue_item_t mem_q [plm_pkg::QueueDepth];
	logic [IdxWidth-1:0]  wr_ptr_q;
	logic [IdxWidth-1:0]  rd_ptr_q;
	logic [CntWidth-1:0]  count_q;
	logic                 do_push;
	logic                 do_pop;

	assign status.not_empty = count_q != '0;
	assign status.not_full  = count_q != CntWidth'(plm_pkg::QueueDepth);
	assign status.head      = mem_q[rd_ptr_q];
	assign do_push          = push && status.not_full;
	assign do_pop           = pop && status.not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/plm_back.sv -----
// back end: log2 by squaring pipeline, dB target, meter release, output register
module plm_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  plm_pkg::queue_status_t          q_status,
	output logic                            pop,
	input  logic [plm_pkg::GainWidth-1:0]   decay_gain,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [plm_pkg::ChWidth-1:0]     out_channel,
	output logic [plm_pkg::LevelWidth-1:0]  out_level
);

	localparam int N = plm_pkg::SqSteps;
	localparam int MW = plm_pkg::MantWidth;

	logic adv;

	// normalize stage
	logic                              valid_s1;
	logic [plm_pkg::ChWidth-1:0]       ch_s1;
	logic                              zero_s1;
	logic [plm_pkg::ShiftWidth-1:0]    lz_s1;
	logic [MW-1:0]                     m_s1;
	logic [plm_pkg::ShiftWidth-1:0]    lz_c;
	logic [MW-1:0]                     m_c;

	// squaring stages
	logic                              valid_s2 [N];
	logic [plm_pkg::ChWidth-1:0]       ch_s2    [N];
	logic                              zero_s2  [N];
	logic [plm_pkg::ShiftWidth-1:0]    lz_s2    [N];
	logic [MW-1:0]                     m_s2     [N];
	logic [plm_pkg::FracWidth-1:0]     f_s2     [N];

	// scale multiply stage
	logic                              valid_s3;
	logic [plm_pkg::ChWidth-1:0]       ch_s3;
	logic                              zero_s3;
	logic [41:0]                       prod_s3;
	logic [20:0]                       n_c;

	// target stage
	logic                              valid_s4;
	logic [plm_pkg::ChWidth-1:0]       ch_s4;
	logic [plm_pkg::LevelWidth-1:0]    target_s4;
	logic [42:0]                       ceil_sum;
	logic [10:0]                       steps;
	logic [7:0]                        tgt_int;

	// meter update
	logic [plm_pkg::LevelWidth-1:0]    meter_q [plm_pkg::Channels];
	logic [plm_pkg::LevelWidth-1:0]    cur_meter;
	logic [plm_pkg::LevelWidth-1:0]    diff;
	logic [2*plm_pkg::LevelWidth-1:0]  rel_prod;
	logic [plm_pkg::LevelWidth-1:0]    new_meter;
	logic                              out_valid_q;
	logic [plm_pkg::ChWidth-1:0]       out_ch_q;
	logic [plm_pkg::LevelWidth-1:0]    out_level_q;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && q_status.not_empty;

	always_comb begin
		lz_c = '0;
		for (int i = 0; i < plm_pkg::SampleWidth; i++) begin
			if (q_status.head.peak[i]) begin
				lz_c = plm_pkg::ShiftWidth'(plm_pkg::SampleWidth - 1 - i);
			end
		end
		m_c = {q_status.head.peak, 7'b0} << lz_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_status.not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1   <= q_status.head.ch;
			zero_s1 <= q_status.head.peak == '0;
			lz_s1   <= lz_c;
			m_s1    <= m_c;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_sq
		logic                          v_in;
		logic [plm_pkg::ChWidth-1:0]   ch_in;
		logic                          z_in;
		logic [plm_pkg::ShiftWidth-1:0] lz_in;
		logic [MW-1:0]                 m_in;
		logic [plm_pkg::FracWidth-1:0] f_in;
		logic [2*MW-1:0]               sq;

		if (k == 0) begin : g_first
			assign v_in  = valid_s1;
			assign ch_in = ch_s1;
			assign z_in  = zero_s1;
			assign lz_in = lz_s1;
			assign m_in  = m_s1;
			assign f_in  = '0;
		end else begin : g_next
			assign v_in  = valid_s2[k-1];
			assign ch_in = ch_s2[k-1];
			assign z_in  = zero_s2[k-1];
			assign lz_in = lz_s2[k-1];
			assign m_in  = m_s2[k-1];
			assign f_in  = f_s2[k-1];
		end

		assign sq = m_in * m_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s2[k] <= 1'b0;
			end else if (adv) begin
				valid_s2[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ch_s2[k]   <= ch_in;
				zero_s2[k] <= z_in;
				lz_s2[k]   <= lz_in;
				f_s2[k]    <= {f_in[plm_pkg::FracWidth-2:0], sq[2*MW-1]};
				m_s2[k]    <= sq[2*MW-1] ? sq[2*MW-1:MW] : sq[2*MW-2:MW-1];
			end
		end
	end

	assign n_c = {lz_s2[N-1], 16'b0} - {5'b0, f_s2[N-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2[N-1];
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s3   <= ch_s2[N-1];
			zero_s3 <= zero_s2[N-1];
			prod_s3 <= n_c * plm_pkg::LogScaleQ16;
		end
	end

	assign ceil_sum = {1'b0, prod_s3} + 43'h0_FFFF_FFFF;
	assign steps    = ceil_sum[42:32];
	assign tgt_int  = (zero_s3 || steps > plm_pkg::FloorSteps) ? plm_pkg::FloorLevel
		: 8'(11'(plm_pkg::TopLevel) - steps);

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s4     <= ch_s3;
			target_s4 <= {tgt_int, 8'b0};
		end
	end

	assign cur_meter = meter_q[ch_s4];
	assign diff      = cur_meter - target_s4;
	assign rel_prod  = diff * decay_gain;
	assign new_meter = (cur_meter > target_s4) ? (cur_meter - rel_prod[31:16]) : target_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < plm_pkg::Channels; i++) begin
				meter_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s4;
			if (valid_s4) begin
				meter_q[ch_s4] <= new_meter;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s4) begin
			out_ch_q    <= ch_s4;
			out_level_q <= new_meter;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;
	assign out_level   = out_level_q;

endmodule

// ----- src/plm_checker.sv -----
// port-level assertions for the peak level meter and their bind
module plm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_level,
	input logic        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("meter transaction dropped while stalled");

	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_level <= {plm_pkg::TopLevel, 8'b0})
		else $error("meter level above top of scale");

	a_level_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_level >= {plm_pkg::FloorLevel, 8'b0})
		else $error("meter level below floor");

	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");

endmodule

bind peak_level_meter plm_checker u_plm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (meter.valid),
	.out_ready (meter.ready),
	.out_level (meter.meter_level),
	.pready    (pready)
);

// ----- dv/peak_level_meter_tb.sv -----
// testbench of the peak level meter: directed table, then random buffers checked by a predictor
`timescale 1ns / 100ps

module peak_level_meter_tb;
	import plm_pkg::*;

	typedef struct packed {
		logic [ChWidth-1:0]    ch;
		logic [LevelWidth-1:0] level;
	} reading_t;

	typedef struct packed {
		logic [ChWidth-1:0]     ch;
		logic [SampleWidth-1:0] sample;
		logic                   last;
		logic                   typed;
		logic [LevelWidth-1:0]  level;
	} stim_row_t;

	localparam int HoldCycles    = 400;
	localparam int SettleCycles  = 40;
	localparam int IdleLimit     = 3000;
	localparam int MaxPrinted    = 40;
	localparam int PhaseCount    = 6;
	localparam int PhaseItems    = 290;
	localparam int DirectedCount = 21;
	localparam int SpareRegIndex = 1;
	localparam int LevelTop      = 248;
	localparam int StepsAtFloor  = 240;
	localparam logic [LevelWidth-1:0] FloorQ88    = 16'h0800;
	localparam logic [LevelWidth-1:0] TopQ88      = 16'hF800;
	localparam logic [GainWidth-1:0]  DefaultGain = 16'd3277;
	localparam longint unsigned QuarterDbPerOctaveQ16 = 64'd1578264;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PaddrWidth-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	plm_in_if  samples_if ();
	plm_out_if meter_if ();

	peak_level_meter u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.meter   (meter_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [GainWidth-1:0]   model_gain;
	logic [SampleWidth-1:0] model_peak [Channels];
	logic [LevelWidth-1:0]  model_meter [Channels];
	reading_t               pending_readings [$];
	int                     mismatch_count = 0;
	int                     idle_cycles = 0;
	int                     burst_left = 0;
	bit                     hold_request = 1'b0;

	int unsigned phase_gain [PhaseCount] = '{0, 65535, 1, 32768, 0, 3277};
	int          phase_blen [PhaseCount] = '{3, 12, 6, 20, 8, 1};

	stim_row_t directed_rows [DirectedCount] = '{
		'{3'd0, 24'h000000, 1'b1, 1'b1, FloorQ88},   // zero peak
		'{3'd1, 24'h800000, 1'b1, 1'b1, TopQ88},     // most negative sample
		'{3'd2, 24'h7FFFFF, 1'b1, 1'b0, 16'h0000},
		'{3'd3, 24'h000001, 1'b1, 1'b1, FloorQ88},   // far below -60 dB
		'{3'd1, 24'h000000, 1'b1, 1'b0, 16'h0000},   // release from top
		'{3'd4, 24'h000064, 1'b0, 1'b0, 16'h0000},
		'{3'd4, 24'hFFEC78, 1'b0, 1'b0, 16'h0000},
		'{3'd4, 24'h00012C, 1'b1, 1'b0, 16'h0000},
		'{3'd5, 24'h7FFFFF, 1'b0, 1'b0, 16'h0000},
		'{3'd6, 24'h0020C4, 1'b1, 1'b0, 16'h0000},   // around -60 dB
		'{3'd5, 24'h800000, 1'b0, 1'b0, 16'h0000},
		'{3'd6, 24'h0020C5, 1'b1, 1'b0, 16'h0000},
		'{3'd5, 24'h000010, 1'b1, 1'b1, TopQ88},     // peak held over the buffer
		'{3'd7, 24'hFFFFFF, 1'b1, 1'b1, FloorQ88},
		'{3'd7, 24'h400000, 1'b1, 1'b0, 16'h0000},
		'{3'd7, 24'h000000, 1'b1, 1'b0, 16'h0000},
		'{3'd7, 24'h000000, 1'b1, 1'b0, 16'h0000},
		'{3'd0, 24'h555555, 1'b0, 1'b0, 16'h0000},
		'{3'd0, 24'hAAAAAA, 1'b1, 1'b0, 16'h0000},
		'{3'd2, 24'h7FFFFF, 1'b1, 1'b0, 16'h0000},   // meter equal to target
		'{3'd3, 24'h000800, 1'b1, 1'b0, 16'h0000}
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [LevelWidth-1:0] level_target(input logic [SampleWidth-1:0] peak);
		int               msb;
		int               b;
		int               i;
		int               steps;
		longint unsigned  mant;
		longint unsigned  neg_log2;
		logic [FracWidth-1:0] frac;
		if (peak == '0)
			return FloorQ88;
		msb = 0;
		for (b = 0; b < SampleWidth; b++)
			if (peak[b])
				msb = b;
		mant = 64'(peak) << (30 - msb);
		frac = '0;
		for (i = 0; i < FracWidth; i++) begin
			mant = (mant * mant) >> 30;
			frac = {frac[FracWidth-2:0], 1'b0};
			if (mant >= (64'd2 << 30)) begin
				frac[0] = 1'b1;
				mant = mant >> 1;
			end
		end
		neg_log2 = 64'(23 - msb) * 64'd65536 - 64'(frac);
		steps = -int'((neg_log2 * QuarterDbPerOctaveQ16 + 64'hFFFF_FFFF) >> 32);
		if (steps < -StepsAtFloor)
			return FloorQ88;
		return LevelWidth'((LevelTop + steps) << 8);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MaxPrinted)
			$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	task automatic clear_meter_model();
		int c;
		model_gain = DefaultGain;
		for (c = 0; c < Channels; c++) begin
			model_peak[c] = '0;
			model_meter[c] = '0;
		end
	endtask

	// accepted sample: track peak, on buffer end release the meter and queue the reading
	task automatic take_sample(input stim_row_t row);
		logic [SampleWidth-1:0] mag;
		logic [LevelWidth-1:0]  target;
		logic [LevelWidth-1:0]  level;
		longint unsigned        drop;
		mag = row.sample[SampleWidth-1] ? ~row.sample + 1'b1 : row.sample;
		if (mag > model_peak[row.ch])
			model_peak[row.ch] = mag;
		if (row.last) begin
			target = level_target(model_peak[row.ch]);
			level = model_meter[row.ch];
			if (level > target) begin
				drop = ((64'(level) - 64'(target)) * 64'(model_gain)) >> 16;
				level = level - LevelWidth'(drop);
			end else begin
				level = target;
			end
			model_meter[row.ch] = level;
			model_peak[row.ch] = '0;
			pending_readings.push_back(reading_t'{ch: row.ch, level: row.typed ? row.level : level});
		end
	endtask

	task automatic send_sample(input stim_row_t row);
		int r;
		int gap;
		@(negedge clk);
		r = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if (r < 5) begin
			burst_left = $urandom_range(20, 80);
			gap = 0;
		end else if (r < 60) begin
			gap = 0;
		end else if (r < 90) begin
			gap = $urandom_range(1, 3);
		end else if (r < 98) begin
			gap = $urandom_range(4, 12);
		end else begin
			gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.channel <= row.ch;
		samples_if.sample_value <= row.sample;
		samples_if.last_of_buffer <= row.last;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		take_sample(row);
	endtask

	task automatic settle_block();
		@(negedge clk);
		samples_if.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [PaddrWidth-1:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_register(input int index, input logic [31:0] value);
		logic [31:0] unused;
		apb_access(1'b1, PaddrWidth'(4 * index), value, unused);
		if (index == int'(RegDecayGain))
			model_gain = value[GainWidth-1:0];
	endtask

	task automatic check_gain_readback();
		logic [31:0] got;
		apb_access(1'b0, PaddrWidth'(4 * int'(RegDecayGain)), 32'h0, got);
		if (got !== 32'(model_gain))
			report_mismatch($sformatf("decay_gain read %0d expected %0d", got, model_gain));
	endtask

	initial begin : meter_receiver
		int   r;
		int   run;
		logic go;
		meter_if.ready = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (hold_request) begin
				hold_request = 1'b0;
				go = 1'b0;
				run = HoldCycles;
			end else if (r < 45) begin
				go = 1'b1;
				run = $urandom_range(1, 30);
			end else if (r < 50) begin
				go = 1'b1;
				run = $urandom_range(100, 300);
			end else if (r < 85) begin
				go = 1'b0;
				run = $urandom_range(1, 4);
			end else if (r < 97) begin
				go = 1'b0;
				run = $urandom_range(5, 20);
			end else begin
				go = 1'b0;
				run = $urandom_range(30, 80);
			end
			@(negedge clk);
			meter_if.ready <= go;
			repeat (run - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if ((samples_if.valid && samples_if.ready) || (meter_if.valid && meter_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (meter_if.valid && meter_if.ready) begin
				if (pending_readings.size() == 0) begin
					report_mismatch($sformatf("transaction with nothing pending, channel %0d level %0d",
						meter_if.meter_channel, meter_if.meter_level));
				end else begin
					want = pending_readings.pop_front();
					if (meter_if.meter_channel !== want.ch)
						report_mismatch($sformatf("meter_channel %0d expected %0d",
							meter_if.meter_channel, want.ch));
					if (meter_if.meter_level !== want.level)
						report_mismatch($sformatf("channel %0d meter_level %0d expected %0d",
							want.ch, meter_if.meter_level, want.level));
				end
			end
			if (idle_cycles >= IdleLimit) begin
				$display("peak_level_meter_tb: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int                            p;
		int                            k;
		int                            r;
		int                            sh;
		stim_row_t                     row;
		logic [GainWidth-1:0]          gain;
		logic signed [SampleWidth-1:0] raw;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		samples_if.valid = 1'b0;
		samples_if.channel = '0;
		samples_if.sample_value = '0;
		samples_if.last_of_buffer = 1'b0;
		clear_meter_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_gain_readback();

		for (k = 0; k < DirectedCount; k++)
			send_sample(directed_rows[k]);
		settle_block();

		for (p = 0; p < PhaseCount; p++) begin
			gain = (p == 4) ? GainWidth'($urandom()) : GainWidth'(phase_gain[p]);
			write_register(SpareRegIndex, $urandom());
			write_register(int'(RegDecayGain), {16'($urandom()), gain});
			check_gain_readback();
			// short buffers while the receiver holds off, so the queue fills
			if (p == 0)
				hold_request = 1'b1;
			for (k = 0; k < PhaseItems; k++) begin
				r = $urandom_range(0, 19);
				sh = $urandom_range(0, SampleWidth - 1);
				raw = SampleWidth'($urandom());
				row.ch = ChWidth'($urandom_range(0, Channels - 1));
				if (r == 0)
					row.sample = 24'h000000;
				else if (r == 1)
					row.sample = 24'h800000;
				else if (r == 2)
					row.sample = 24'h7FFFFF;
				else
					row.sample = raw >>> sh;
				row.last = ($urandom_range(1, phase_blen[p]) == 1);
				row.typed = 1'b0;
				row.level = '0;
				send_sample(row);
			end
			settle_block();
		end

		if (mismatch_count == 0)
			$display("peak_level_meter_tb: clean");
		else
			$display("peak_level_meter_tb: errors");
		$finish;
	end

endmodule

// ----- files.f -----
src/plm_pkg.sv
src/plm_if.sv
src/plm_front.sv
src/plm_queue.sv
src/plm_back.sv
src/peak_level_meter.sv
src/plm_checker.sv
dv/peak_level_meter_tb.sv
